// File: hw/rtl/wtsc_pkg.sv
`default_nettype none

package wtsc_pkg;

   localparam int WAVE_BYTES = 16;
   localparam int WAVE_ADDR_W = $clog2(WAVE_BYTES);
   localparam int FREQ_W = 11;
   localparam int TIMER_W = 13;
   localparam int POS_W = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = FREQ_W;

   typedef enum logic [1:0] {
      REQ_ADVANCE = 2'd0,
      REQ_TRIGGER = 2'd1,
      REQ_WRITE   = 2'd2,
      REQ_UNUSED  = 2'd3
   } req_code_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FREQUENCY    = 2'd0,
      CSR_VOLUME_LEVEL = 2'd1,
      CSR_DAC_ENABLE   = 2'd2,
      CSR_NONE         = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [7:0]             cycle_count;
      logic [WAVE_ADDR_W-1:0] wave_addr;
      logic [7:0]             wave_data;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] amplitude;
      logic       channel_on;
   } rsp_payload_type;

   // microcode
   typedef logic [2:0] step_type;

   localparam step_type STEP_CAPTURE = 3'd0;
   localparam step_type STEP_ADVANCE = 3'd1;
   localparam step_type STEP_TRIGGER = 3'd2;
   localparam step_type STEP_WRITE   = 3'd3;
   localparam step_type STEP_EMIT    = 3'd4;

   typedef enum logic [2:0] {
      DP_NOP     = 3'd0,
      DP_CAPTURE = 3'd1,
      DP_ADVANCE = 3'd2,
      DP_TRIGGER = 3'd3,
      DP_WRITE   = 3'd4,
      DP_EMIT    = 3'd5
   } dp_op_type;

   typedef enum logic [1:0] {
      SEQ_GOTO     = 2'd0,
      SEQ_DISPATCH = 2'd1,
      SEQ_LOOP     = 2'd2,
      SEQ_EMIT     = 2'd3
   } seq_op_type;

   typedef struct packed {
      dp_op_type  dp_op;
      seq_op_type seq_op;
      step_type   target;
   } ctrl_word_type;

   typedef struct packed {
      logic         accept;
      req_code_type req_code;
      logic         expire;
      logic         out_free;
   } seq_cond_type;

   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type word;
      case (step)
         STEP_CAPTURE: word = '{dp_op: DP_CAPTURE, seq_op: SEQ_DISPATCH, target: STEP_CAPTURE};
         STEP_ADVANCE: word = '{dp_op: DP_ADVANCE, seq_op: SEQ_LOOP,     target: STEP_EMIT};
         STEP_TRIGGER: word = '{dp_op: DP_TRIGGER, seq_op: SEQ_GOTO,     target: STEP_EMIT};
         STEP_WRITE:   word = '{dp_op: DP_WRITE,   seq_op: SEQ_GOTO,     target: STEP_EMIT};
         STEP_EMIT:    word = '{dp_op: DP_EMIT,    seq_op: SEQ_EMIT,     target: STEP_CAPTURE};
         default:      word = '{dp_op: DP_NOP,     seq_op: SEQ_GOTO,     target: STEP_CAPTURE};
      endcase
      return word;
   endfunction

   function automatic step_type dispatch_step(input req_code_type code);
      step_type step;
      case (code)
         REQ_ADVANCE: step = STEP_ADVANCE;
         REQ_TRIGGER: step = STEP_TRIGGER;
         REQ_WRITE:   step = STEP_WRITE;
         default:     step = STEP_EMIT;
      endcase
      return step;
   endfunction

   // (2048 - f) * 2, frequency zero gives 4096
   function automatic logic [TIMER_W-1:0] period_len(input logic [FREQ_W-1:0] freq);
      logic [FREQ_W:0] diff;
      diff = (FREQ_W+1)'(2048) - {1'b0, freq};
      return {diff, 1'b0};
   endfunction

   function automatic logic [2:0] level_shift(input logic [1:0] level);
      logic [2:0] sh;
      case (level)
         2'd0:    sh = 3'd4;
         2'd1:    sh = 3'd0;
         2'd2:    sh = 3'd1;
         default: sh = 3'd2;
      endcase
      return sh;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/wave_table_sound_channel_unit.sv
// wave table sound channel
// req channel: one transfer per request (advance time, trigger, or write one
// wave store byte). rsp channel: exactly one transfer per request, in order,
// carrying the amplitude and the channel on flag after that request.
// csr port: write enable, index (0 frequency, 1 volume level, 2 dac enable)
// and data; writes are registered. writes must be made only while the unit
// is idle; the unit itself does not enforce this. a microcode sequencer runs
// each request: one capture step, the work steps, then one step that loads
// the output register. trigger and write go through their own work step, the
// unused code straight to the load step, and an advance stays in its work
// step while the timer expires (one expiry per cycle of the advance loop, at
// most 128 at the shortest period). the result is valid the cycle after the
// load step. req_stall is high during reset and outside the capture step.
// the output register holds its result while rsp_stall is high; the sequencer
// waits in the load step until the register is free, so a new request can be
// taken while the previous result still waits.
// after reset: wave store, position, current byte and channel flag are zero,
// the timer is a full period of 4096 and all csr registers are zero.
`default_nettype none

module wave_table_sound_channel_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire wtsc_pkg::req_payload_type            req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output wtsc_pkg::rsp_payload_type                 rsp_data,
   input  wire logic                                 csr_write_enable,
   input  wire logic [wtsc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [wtsc_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   wtsc_pkg::ctrl_word_type ctrl;
   wtsc_pkg::seq_cond_type  cond;

   logic req_accept;
   logic expire;
   logic out_free;

   // csr
   logic [wtsc_pkg::FREQ_W-1:0] frequency_ff;
   logic [1:0]                  volume_level_ff;
   logic                        dac_enable_ff;

   // captured request
   wtsc_pkg::req_code_type         req_code_ff;
   logic [7:0]                     cycle_count_ff, cycle_count_in;
   logic [wtsc_pkg::WAVE_ADDR_W-1:0] wave_addr_ff;
   logic [7:0]                     wave_data_ff;

   // channel state
   logic [wtsc_pkg::TIMER_W-1:0] period_timer_ff, period_timer_in;
   logic [wtsc_pkg::POS_W-1:0]   sample_position_ff, sample_position_in;
   logic [7:0]                   current_byte_ff, current_byte_in;
   logic                         channel_enabled_ff, channel_enabled_in;
   logic [7:0]                   wave_store_ff [wtsc_pkg::WAVE_BYTES];

   logic                      rsp_valid_ff, rsp_valid_in;
   wtsc_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [wtsc_pkg::POS_W-1:0]   position_step;
   logic [wtsc_pkg::TIMER_W-1:0] reload;
   logic [3:0]                   nibble;
   logic [3:0]                   amplitude;

   assign req_stall  = reset || (ctrl.dp_op != wtsc_pkg::DP_CAPTURE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign expire        = {{(wtsc_pkg::TIMER_W-8){1'b0}}, cycle_count_ff} >= period_timer_ff;
   assign position_step = sample_position_ff + wtsc_pkg::POS_W'(1);
   assign reload        = wtsc_pkg::period_len(frequency_ff);

   assign nibble    = sample_position_ff[0] ? current_byte_ff[3:0] : current_byte_ff[7:4];
   assign amplitude = channel_enabled_ff ? (nibble >> wtsc_pkg::level_shift(volume_level_ff))
                                         : 4'd0;

   always_comb begin
      cond.accept   = req_accept;
      cond.req_code = wtsc_pkg::req_code_type'(req_data.req_type);
      cond.expire   = expire;
      cond.out_free = out_free;
   end

   wtsc_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctrl  (ctrl)
   );

   // datapath
   always_comb begin
      cycle_count_in     = cycle_count_ff;
      period_timer_in    = period_timer_ff;
      sample_position_in = sample_position_ff;
      current_byte_in    = current_byte_ff;
      channel_enabled_in = channel_enabled_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_data_in        = rsp_data_ff;
      case (ctrl.dp_op)
         wtsc_pkg::DP_CAPTURE: begin
            if (req_accept) begin
               cycle_count_in = req_data.cycle_count;
            end
         end
         wtsc_pkg::DP_ADVANCE: begin
            if (expire) begin
               // timer fits in the count here, so the low byte is exact
               cycle_count_in     = cycle_count_ff - period_timer_ff[7:0];
               period_timer_in    = reload;
               sample_position_in = position_step;
               current_byte_in    = wave_store_ff[position_step[wtsc_pkg::POS_W-1:1]];
            end else begin
               period_timer_in = period_timer_ff
                                 - {{(wtsc_pkg::TIMER_W-8){1'b0}}, cycle_count_ff};
            end
         end
         wtsc_pkg::DP_TRIGGER: begin
            channel_enabled_in = dac_enable_ff;
            sample_position_in = '0;
            period_timer_in    = reload;
            current_byte_in    = wave_store_ff[0];
         end
         wtsc_pkg::DP_EMIT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.amplitude  = amplitude;
               rsp_data_in.channel_on = channel_enabled_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frequency_ff       <= '0;
         volume_level_ff    <= '0;
         dac_enable_ff      <= 1'b0;
         period_timer_ff    <= wtsc_pkg::period_len('0);
         sample_position_ff <= '0;
         current_byte_ff    <= '0;
         channel_enabled_ff <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         for (int i = 0; i < wtsc_pkg::WAVE_BYTES; i++) begin
            wave_store_ff[i] <= '0;
         end
      end else begin
         period_timer_ff    <= period_timer_in;
         sample_position_ff <= sample_position_in;
         current_byte_ff    <= current_byte_in;
         channel_enabled_ff <= channel_enabled_in;
         rsp_valid_ff       <= rsp_valid_in;
         if (ctrl.dp_op == wtsc_pkg::DP_WRITE) begin
            wave_store_ff[wave_addr_ff] <= wave_data_ff;
         end
         if (csr_write_enable) begin
            case (wtsc_pkg::csr_index_type'(csr_index))
               wtsc_pkg::CSR_FREQUENCY: begin
                  frequency_ff <= csr_write_data[wtsc_pkg::FREQ_W-1:0];
               end
               wtsc_pkg::CSR_VOLUME_LEVEL: begin
                  volume_level_ff <= csr_write_data[1:0];
               end
               wtsc_pkg::CSR_DAC_ENABLE: begin
                  dac_enable_ff <= csr_write_data[0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cycle_count_ff <= cycle_count_in;
      rsp_data_ff    <= rsp_data_in;
      if (req_accept) begin
         req_code_ff  <= wtsc_pkg::req_code_type'(req_data.req_type);
         wave_addr_ff <= req_data.wave_addr;
         wave_data_ff <= req_data.wave_data;
      end
   end

   // the captured code must agree with the step the sequencer went to
   a_dispatch_match: assert property (@(posedge clock) disable iff (reset)
      (ctrl.dp_op == wtsc_pkg::DP_TRIGGER) |-> (req_code_ff == wtsc_pkg::REQ_TRIGGER))
      else $error("trigger step without a trigger request");

   a_timer_nonzero: assert property (@(posedge clock) disable iff (reset)
      period_timer_ff != '0)
      else $error("period timer reached zero");

   a_expire_steps_position: assert property (@(posedge clock) disable iff (reset)
      (ctrl.dp_op == wtsc_pkg::DP_ADVANCE && expire)
      |=> (sample_position_ff == wtsc_pkg::POS_W'($past(sample_position_ff) + 1'b1)))
      else $error("expiry did not step the position");

   a_advance_ends_in_emit: assert property (@(posedge clock) disable iff (reset)
      (ctrl.dp_op == wtsc_pkg::DP_ADVANCE && !expire) |=> (ctrl.dp_op == wtsc_pkg::DP_EMIT))
      else $error("advance loop did not end in the emit step");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.dp_op == wtsc_pkg::DP_EMIT))
      else $error("result raised outside the emit step");

endmodule

`default_nettype wire

// File: hw/rtl/wtsc_sequencer.sv
`default_nettype none

module wtsc_sequencer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire wtsc_pkg::seq_cond_type  cond,
   output wtsc_pkg::ctrl_word_type      ctrl
);

   wtsc_pkg::step_type step_ff;
   wtsc_pkg::step_type step_in;

   assign ctrl = wtsc_pkg::ucode_rom(step_ff);

   always_comb begin
      step_in = step_ff;
      case (ctrl.seq_op)
         wtsc_pkg::SEQ_GOTO: begin
            step_in = ctrl.target;
         end
         wtsc_pkg::SEQ_DISPATCH: begin
            if (cond.accept) begin
               step_in = wtsc_pkg::dispatch_step(cond.req_code);
            end
         end
         wtsc_pkg::SEQ_LOOP: begin
            // keep stepping while another period fits
            if (!cond.expire) begin
               step_in = ctrl.target;
            end
         end
         wtsc_pkg::SEQ_EMIT: begin
            if (cond.out_free) begin
               step_in = ctrl.target;
            end
         end
         default: begin
            step_in = wtsc_pkg::STEP_CAPTURE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= wtsc_pkg::STEP_CAPTURE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire
